### rtl/core/sha256_hash_core_unit_defines.svh
// assertion macros for the sha-256 hash core
`ifndef SHA256_HASH_CORE_UNIT_DEFINES_SVH
`define SHA256_HASH_CORE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/shc_pkg.sv
// shared constants, functions and control types of the sha-256 hash core
package shc_pkg;

  typedef struct packed {
    logic push;
    logic step;
  } sched_ctl_t;

  typedef struct packed {
    logic init;
    logic round;
    logic fold;
    logic emit;
  } round_ctl_t;

  function automatic logic [31:0] init_value(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6A09E667;
      3'd1: v = 32'hBB67AE85;
      3'd2: v = 32'h3C6EF372;
      3'd3: v = 32'hA54FF53A;
      3'd4: v = 32'h510E527F;
      3'd5: v = 32'h9B05688C;
      3'd6: v = 32'h1F83D9AB;
      default: v = 32'h5BE0CD19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
      6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
      6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
      6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### rtl/core/shc_sched.sv
// message window shift line with in-place schedule expansion
module shc_sched (
  input  logic                  clk_i,
  input  shc_pkg::sched_ctl_t   ctl_i,
  input  logic [31:0]           word_i,
  output logic [31:0]           wt_o
);

  logic [31:0] win_q [16];
  logic [31:0] expand;
  logic [31:0] shift_in;

  assign expand = shc_pkg::small_sigma1(win_q[14]) + win_q[9]
                + shc_pkg::small_sigma0(win_q[1]) + win_q[0];
  assign shift_in = ctl_i.push ? word_i : expand;
  assign wt_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= shift_in;
    end
  end

endmodule

### rtl/core/shc_round.sv
// working variables, round unit and chaining values
module shc_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shc_pkg::round_ctl_t   ctl_i,
  input  logic [31:0]           k_i,
  input  logic [31:0]           wt_i,
  input  logic [2:0]            iv_idx_i,
  output logic [31:0]           chain0_o
);

  logic [31:0] work_q  [8];
  logic [31:0] chain_q [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  assign choose = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign major  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
                ^ (work_q[1] & work_q[2]);
  assign t1 = work_q[7] + shc_pkg::big_sigma1(work_q[4]) + choose + k_i + wt_i;
  assign t2 = shc_pkg::big_sigma0(work_q[0]) + major;
  assign chain0_o = chain_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i] <= chain_q[i];
      end
    end else if (ctl_i.round) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= shc_pkg::init_value(3'(i));
      end
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + work_q[i];
      end
    end else if (ctl_i.emit) begin
      // rotate words out, refill with the initial vector behind them
      for (int i = 0; i < 7; i++) begin
        chain_q[i] <= chain_q[i+1];
      end
      chain_q[7] <= shc_pkg::init_value(iv_idx_i);
    end
  end

endmodule

### rtl/core/sha256_hash_core_unit.sv
// top level of the sha-256 hash core: sequencer and stream ports
//
// input stream: one message byte per word; tuser set means the word carries
// no byte, tlast marks the end of the message (a byte with tlast is absorbed
// first). output stream: eight 32-bit digest words, h0 first, tuser holds
// the word position and tlast marks the eighth word.
// bytes are taken one per cycle while the input is ready; the 64th byte of a
// block starts 64 rounds of the single round unit, followed by a fold into the
// chaining values.
// the end of a message feeds 9 to 72 pad and length bytes one per cycle outside
// the rounds, with a pass through the zero state that places no byte before the
// length field, and runs one or two compressions before the digest.
// the input is not ready during rounds, padding or digest output.
// the output holds its word while tready is low; the block returns to
// accepting bytes the cycle after the eighth word is taken.
// reset loads the initial hash values and clears all counters.
`include "sha256_hash_core_unit_defines.svh"

module sha256_hash_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] no_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MARK  = 7'b0000010,
    ST_ZERO  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  state_e      resume_q, resume_d;
  state_e      after;
  logic [5:0]  pos_q, pos_d;
  logic [23:0] acc_q, acc_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [2:0]  ocnt_q, ocnt_d;
  logic        in_hs, out_hs;
  logic        feed, place, block_full;
  logic [7:0]  pbyte;

  shc_pkg::sched_ctl_t sched_ctl;
  shc_pkg::round_ctl_t round_ctl;
  logic [31:0]         wt;
  logic [31:0]         chain0;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign in_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    after    = state_q;
    feed     = 1'b0;
    place    = 1'b0;
    pbyte    = s_axis_tdata_i;
    pos_d    = pos_q;
    acc_d    = acc_q;
    bits_d   = bits_q;
    rnd_d    = rnd_q;
    lcnt_d   = lcnt_q;
    ocnt_d   = ocnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          feed  = 1'b1;
          place = !s_axis_tuser_i;
          after = s_axis_tlast_i ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        feed  = 1'b1;
        place = 1'b1;
        pbyte = 8'h80;
        after = ST_ZERO;
      end
      ST_ZERO: begin
        feed  = 1'b1;
        pbyte = 8'h00;
        if (pos_q == 6'd56) begin
          after = ST_LEN;
        end else begin
          place = 1'b1;
          after = ST_ZERO;
        end
      end
      ST_LEN: begin
        feed  = 1'b1;
        place = 1'b1;
        pbyte = bits_q[63:56];
        after = (lcnt_q == 3'd7) ? ST_EMIT : ST_LEN;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_d = resume_q;
      end
      ST_EMIT: begin
        if (out_hs) begin
          ocnt_d = ocnt_q + 3'd1;
          if (ocnt_q == 3'd7) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    block_full = place && (pos_q == 6'd63);

    if (feed) begin
      if (block_full) begin
        state_d  = ST_ROUND;
        resume_d = after;
      end else begin
        state_d = after;
      end
    end

    if (place) begin
      pos_d = pos_q + 6'd1;
      acc_d = {acc_q[15:0], pbyte};
      if (state_q == ST_IDLE) begin
        bits_d = bits_q + 64'd8;
      end
      if (state_q == ST_LEN) begin
        bits_d = {bits_q[55:0], 8'h00};
        lcnt_d = lcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      resume_q <= ST_IDLE;
      pos_q    <= '0;
      bits_q   <= '0;
      rnd_q    <= '0;
      lcnt_q   <= '0;
      ocnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      pos_q    <= pos_d;
      bits_q   <= bits_d;
      rnd_q    <= rnd_d;
      lcnt_q   <= lcnt_d;
      ocnt_q   <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sched_ctl.push  = place && (pos_q[1:0] == 2'd3);
  assign sched_ctl.step  = (state_q == ST_ROUND);
  assign round_ctl.init  = block_full;
  assign round_ctl.round = (state_q == ST_ROUND);
  assign round_ctl.fold  = (state_q == ST_FOLD);
  assign round_ctl.emit  = out_hs;

  shc_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (sched_ctl),
    .word_i ({acc_q, pbyte}),
    .wt_o   (wt)
  );

  shc_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (round_ctl),
    .k_i      (shc_pkg::round_k(rnd_q)),
    .wt_i     (wt),
    .iv_idx_i (ocnt_q),
    .chain0_o (chain0)
  );

  assign m_axis_tdata_o = chain0;
  assign m_axis_tuser_o = ocnt_q;
  assign m_axis_tlast_o = (ocnt_q == 3'd7);

  `SHC_ASSERT_NOW(a_one_side_open, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o, "input open during digest output")
  `SHC_ASSERT_NEXT(a_idle_after_digest, clk_i, rst_ni, out_hs && m_axis_tlast_o, s_axis_tready_o, "not ready after final word")
  `SHC_ASSERT_NOW(a_last_is_eighth, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o == 3'd7, "tlast on wrong word")
  `SHC_ASSERT_NOW(a_round_count_idle, clk_i, rst_ni, state_q != ST_ROUND, rnd_q == 6'd0, "round counter left running")

endmodule
